// ----- design/slpc_pkg.sv -----
//------------------------------------------------------------------------------
// slpc_pkg
// Shared types, codes and pattern tables of the status LED pattern controller.
//------------------------------------------------------------------------------
`default_nettype none

package slpc_pkg;

	localparam int NUM_LEDS_DEF = 8;
	localparam int MAX_STRIP    = 8;

	localparam logic [1:0] KIND_TICK         = 2'd0;
	localparam logic [1:0] KIND_PATTERN      = 2'd1;
	localparam logic [1:0] KIND_STATUS_FLASH = 2'd2;
	localparam logic [1:0] KIND_STRIP_FLASH  = 2'd3;

	localparam logic [1:0] PAT_WIFI   = 2'd0;
	localparam logic [1:0] PAT_ESPNOW = 2'd1;
	localparam logic [1:0] PAT_RAPID  = 2'd2;
	localparam logic [1:0] PAT_OTA    = 2'd3;

	localparam logic [1:0] REG_BUILTIN_FLASH_MS = 2'd0;
	localparam logic [1:0] REG_MODE_ON_MS       = 2'd1;
	localparam logic [1:0] REG_MODE_OFF_MS      = 2'd2;

	localparam logic [15:0] BUILTIN_FLASH_RST = 16'd60;
	localparam logic [15:0] MODE_ON_RST       = 16'd200;
	localparam logic [15:0] MODE_OFF_RST      = 16'd3000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  pattern;
		logic [7:0]  led_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] duration;
	} slpc_item_t;

	typedef struct packed {
		logic       led_level;
		logic       write_valid;
		logic [2:0] strip_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       last;
	} slpc_result_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} slpc_rgb_t;

	typedef struct packed {
		logic exec;
		logic load;
	} slpc_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_pick;
	} slpc_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} slpc_state_t;

	function automatic logic [15:0] step_len(input logic [1:0] p, input logic [1:0] s);
		logic [15:0] len;
		unique case (p)
			PAT_WIFI: begin
				unique case (s)
					2'd0: len = 16'd80;
					2'd1: len = 16'd150;
					2'd2: len = 16'd80;
					default: len = 16'd1690;
				endcase
			end
			PAT_ESPNOW: len = s[0] ? 16'd1920 : 16'd80;
			PAT_RAPID: len = 16'd100;
			default: len = 16'd50;
		endcase
		return len;
	endfunction

	function automatic slpc_rgb_t mode_rgb(input logic set, input logic [1:0] p);
		slpc_rgb_t c;
		if (!set) begin
			c = '{red: 8'd100, green: 8'd0, blue: 8'd0};
		end else begin
			unique case (p)
				PAT_WIFI: c = '{red: 8'd0, green: 8'd0, blue: 8'd200};
				PAT_ESPNOW: c = '{red: 8'd0, green: 8'd200, blue: 8'd0};
				PAT_RAPID: c = '{red: 8'd200, green: 8'd0, blue: 8'd0};
				default: c = '{red: 8'd200, green: 8'd180, blue: 8'd0};
			endcase
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- design/slpc_item_if.sv -----
//------------------------------------------------------------------------------
// slpc_item_if
// Input item channel: valid/ready handshake with the item payload.
//------------------------------------------------------------------------------
`default_nettype none

interface slpc_item_if;
	logic                   valid;
	logic                   ready;
	slpc_pkg::slpc_item_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/slpc_result_if.sv -----
//------------------------------------------------------------------------------
// slpc_result_if
// Result channel: valid/ready handshake with the result payload.
//------------------------------------------------------------------------------
`default_nettype none

interface slpc_result_if;
	logic                   valid;
	logic                   ready;
	slpc_pkg::slpc_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/slpc_cfg_if.sv -----
//------------------------------------------------------------------------------
// slpc_cfg_if
// Configuration write channel: register index and write data.
//------------------------------------------------------------------------------
`default_nettype none

interface slpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/slpc_ctrl.sv -----
//------------------------------------------------------------------------------
// slpc_ctrl
// Controller: accepts one item, then sequences its results into the output
// register.
//------------------------------------------------------------------------------
`default_nettype none

module slpc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire slpc_pkg::slpc_sts_t sts,
	output slpc_pkg::slpc_cmd_t      cmd
);

	slpc_pkg::slpc_state_t state_q;
	slpc_pkg::slpc_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			slpc_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = slpc_pkg::ST_EMIT;
			end
			slpc_pkg::ST_EMIT: begin
				if (sts.out_free && sts.last_pick) state_nxt = slpc_pkg::ST_IDLE;
			end
			default: state_nxt = slpc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			slpc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.exec = in_valid;
			end
			slpc_pkg::ST_EMIT: begin
				cmd.load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/slpc_datapath.sv -----
//------------------------------------------------------------------------------
// slpc_datapath
// Status LED, mode flash and strip flash state, result selection and output
// register.
//------------------------------------------------------------------------------
`default_nettype none

module slpc_datapath #(
	parameter int NUM_LEDS = slpc_pkg::NUM_LEDS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire slpc_pkg::slpc_item_t   item,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [15:0]            cfg_data,
	input  wire slpc_pkg::slpc_cmd_t    cmd,
	output slpc_pkg::slpc_sts_t         sts,
	output logic                        out_valid,
	output slpc_pkg::slpc_result_t      out_data,
	input  wire logic                   out_ready
);

	localparam int StripCount = (NUM_LEDS < slpc_pkg::MAX_STRIP) ? NUM_LEDS : slpc_pkg::MAX_STRIP;
	localparam int MaskW      = StripCount + 1;

	logic [15:0] cfg_flash_q, cfg_on_q, cfg_off_q;

	logic        set_q, lvl_q, sflash_q, phase_q;
	logic [1:0]  pat_q, step_q;
	logic [15:0] sel_q, sleft_q, mel_q;
	logic        fa_q [StripCount];
	logic [15:0] fl_q [StripCount];
	logic [MaskW-1:0] pend_q;
	logic        hd_rest_q;
	logic [2:0]  hd_idx_q;
	slpc_pkg::slpc_rgb_t hd_rgb_q;
	logic        out_valid_q;
	slpc_pkg::slpc_result_t out_data_q;

	logic        set_n, lvl_n, sflash_n, phase_n;
	logic [1:0]  pat_n, step_n;
	logic [15:0] sel_n, sleft_n, mel_n;
	logic        fa_n [StripCount];
	logic [15:0] fl_n [StripCount];
	logic [MaskW-1:0] pend_n;
	logic        hd_rest_n;

	logic [15:0] left_dec, el_inc, me_inc, cur_len, mode_thr;
	logic [1:0]  cur_s, nxt_s;
	logic        idx_ok;

	// Tick and item update
	always_comb begin
		set_n     = set_q;
		lvl_n     = lvl_q;
		sflash_n  = sflash_q;
		phase_n   = phase_q;
		pat_n     = pat_q;
		step_n    = step_q;
		sel_n     = sel_q;
		sleft_n   = sleft_q;
		mel_n     = mel_q;
		pend_n    = '0;
		hd_rest_n = 1'b1;
		for (int i = 0; i < StripCount; i++) begin
			fa_n[i] = fa_q[i];
			fl_n[i] = fl_q[i];
		end

		left_dec = (sleft_q == 16'd0) ? 16'd0 : sleft_q - 16'd1;
		el_inc   = (sel_q == 16'hFFFF) ? sel_q : sel_q + 16'd1;
		me_inc   = (mel_q == 16'hFFFF) ? mel_q : mel_q + 16'd1;
		cur_s    = (pat_q == slpc_pkg::PAT_WIFI) ? step_q : {1'b0, step_q[0]};
		nxt_s    = (pat_q == slpc_pkg::PAT_WIFI) ? cur_s + 2'd1 : {1'b0, ~cur_s[0]};
		cur_len  = slpc_pkg::step_len(pat_q, cur_s);
		mode_thr = phase_q ? cfg_on_q : cfg_off_q;
		idx_ok   = item.led_index < 8'(StripCount);

		case (item.kind)
			slpc_pkg::KIND_TICK: begin
				if (sflash_q) begin
					sleft_n = left_dec;
					if (left_dec == 16'd0) begin
						sflash_n = 1'b0;
						sel_n    = 16'd0;
						lvl_n    = ~step_q[0];
					end else begin
						lvl_n = 1'b1;
					end
				end else if (set_q) begin
					if (el_inc >= cur_len) begin
						step_n = nxt_s;
						sel_n  = 16'd0;
						lvl_n  = ~nxt_s[0];
					end else begin
						sel_n = el_inc;
					end
				end
				if (me_inc >= mode_thr) begin
					phase_n   = ~phase_q;
					mel_n     = 16'd0;
					pend_n[0] = ~fa_q[0];
				end else begin
					mel_n = me_inc;
				end
				for (int i = 0; i < StripCount; i++) begin
					if (fa_q[i]) begin
						fl_n[i] = (fl_q[i] == 16'd0) ? 16'd0 : fl_q[i] - 16'd1;
						if (fl_n[i] == 16'd0) begin
							fa_n[i]     = 1'b0;
							pend_n[i+1] = 1'b1;
						end
					end
				end
			end
			slpc_pkg::KIND_PATTERN: begin
				if (!(set_q && pat_q == item.pattern && !sflash_q)) begin
					set_n     = 1'b1;
					pat_n     = item.pattern;
					step_n    = 2'd0;
					sel_n     = 16'd0;
					lvl_n     = 1'b1;
					phase_n   = 1'b1;
					mel_n     = 16'd0;
					pend_n[0] = ~fa_q[0];
				end
			end
			slpc_pkg::KIND_STATUS_FLASH: begin
				sleft_n  = cfg_flash_q;
				sflash_n = 1'b1;
				lvl_n    = 1'b1;
			end
			default: begin
				if (idx_ok) begin
					hd_rest_n = 1'b0;
					pend_n[0] = 1'b1;
					for (int i = 0; i < StripCount; i++) begin
						if (item.led_index == 8'(i)) begin
							fa_n[i] = 1'b1;
							fl_n[i] = item.duration;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_flash_q <= slpc_pkg::BUILTIN_FLASH_RST;
			cfg_on_q    <= slpc_pkg::MODE_ON_RST;
			cfg_off_q   <= slpc_pkg::MODE_OFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slpc_pkg::REG_BUILTIN_FLASH_MS: cfg_flash_q <= cfg_data;
				slpc_pkg::REG_MODE_ON_MS: cfg_on_q <= cfg_data;
				slpc_pkg::REG_MODE_OFF_MS: cfg_off_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q    <= 1'b0;
			lvl_q    <= 1'b0;
			sflash_q <= 1'b0;
			phase_q  <= 1'b0;
			pat_q    <= 2'd0;
			step_q   <= 2'd0;
			sel_q    <= 16'd0;
			sleft_q  <= 16'd0;
			mel_q    <= 16'd0;
			for (int i = 0; i < StripCount; i++) begin
				fa_q[i] <= 1'b0;
				fl_q[i] <= 16'd0;
			end
		end else if (cmd.exec) begin
			set_q    <= set_n;
			lvl_q    <= lvl_n;
			sflash_q <= sflash_n;
			phase_q  <= phase_n;
			pat_q    <= pat_n;
			step_q   <= step_n;
			sel_q    <= sel_n;
			sleft_q  <= sleft_n;
			mel_q    <= mel_n;
			for (int i = 0; i < StripCount; i++) begin
				fa_q[i] <= fa_n[i];
				fl_q[i] <= fl_n[i];
			end
		end
	end

	// Result selection: head write first, then expiries in index order
	logic [MaskW-1:0] pick, rest;
	slpc_pkg::slpc_rgb_t restore_rgb;
	slpc_pkg::slpc_result_t res;

	always_comb begin
		pick = pend_q & (~pend_q + MaskW'(1));
		rest = pend_q & ~pick;
		restore_rgb = phase_q ? slpc_pkg::mode_rgb(set_q, pat_q) : '0;
		res = '0;
		res.led_level = lvl_q;
		res.last      = (rest == '0);
		if (pick[0]) begin
			res.write_valid = 1'b1;
			res.strip_index = hd_rest_q ? 3'd0 : hd_idx_q;
			res.out_red     = hd_rest_q ? restore_rgb.red : hd_rgb_q.red;
			res.out_green   = hd_rest_q ? restore_rgb.green : hd_rgb_q.green;
			res.out_blue    = hd_rest_q ? restore_rgb.blue : hd_rgb_q.blue;
		end
		for (int j = 1; j < MaskW; j++) begin
			if (pick[j]) begin
				res.write_valid = 1'b1;
				res.strip_index = 3'(j - 1);
				if (j == 1) begin
					res.out_red   = restore_rgb.red;
					res.out_green = restore_rgb.green;
					res.out_blue  = restore_rgb.blue;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			pend_q <= pend_n;
			if (out_ready) out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			pend_q      <= rest;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			hd_rest_q <= hd_rest_n;
			hd_idx_q  <= item.led_index[2:0];
			hd_rgb_q  <= '{red: item.red, green: item.green, blue: item.blue};
		end
		if (cmd.load) out_data_q <= res;
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.last_pick = res.last;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

endmodule

`default_nettype wire

// ----- design/status_led_pattern_controller.sv -----
//------------------------------------------------------------------------------
// status_led_pattern_controller
// Status LED pattern walker with mode flash on strip LED 0 and one-shot strip
// flashes, driven by millisecond tick items.
//
//   channel     dir  handshake      payload
//   item_in     in   valid/ready    kind, pattern, led_index, red, green,
//                                   blue, duration
//   result_out  out  valid/ready    led_level, write_valid, strip_index,
//                                   out_red, out_green, out_blue, last
//   cfg         in   valid/ready    index (0..2), data (16 bits)
//
// An item is taken when the block is idle; its results then leave one a cycle
// while result_out is not stalled, one to StripCount + 1 results per item.
// The single output register drains the result list.
// Every strip counter is updated in the accept cycle.
// Reset loads defaults, clears state except head/out data; no clearing pass.
// A stall on result_out holds the output register and the result list.
// cfg is always ready.
//------------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_controller #(
	parameter int NUM_LEDS = slpc_pkg::NUM_LEDS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	slpc_item_if.sink     item_in,
	slpc_result_if.source result_out,
	slpc_cfg_if.sink      cfg
);

	localparam int StripCount = (NUM_LEDS < slpc_pkg::MAX_STRIP) ? NUM_LEDS : slpc_pkg::MAX_STRIP;

	slpc_pkg::slpc_cmd_t cmd;
	slpc_pkg::slpc_sts_t sts;
	logic                in_ready;

	assign cfg.ready     = 1'b1;
	assign item_in.ready = in_ready;

	slpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	slpc_datapath #(
		.NUM_LEDS (NUM_LEDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_in.data),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (result_out.valid),
		.out_data  (result_out.data),
		.out_ready (result_out.ready)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.valid && item_in.ready |=> !item_in.ready)
		else $error("item accepted while previous item still in work");

	a_nowrite_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.data.write_valid |->
		result_out.data.last && result_out.data.strip_index == 3'd0 &&
		result_out.data.out_red == 8'd0 && result_out.data.out_green == 8'd0 &&
		result_out.data.out_blue == 8'd0)
		else $error("result without write carries payload or is not last");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.data.write_valid |->
		32'(result_out.data.strip_index) < StripCount)
		else $error("strip write beyond strip length");

	a_level_steady: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.ready && !result_out.data.last |=>
		result_out.valid && $stable(result_out.data.led_level))
		else $error("led level changed within one item");

endmodule

`default_nettype wire
